### src/rounded_multiply_divide_u64_macros.svh
// Assertion helpers shared by the rescale block.
`ifndef ROUNDED_MULTIPLY_DIVIDE_U64_MACROS_SVH
`define ROUNDED_MULTIPLY_DIVIDE_U64_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define RMD_ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("rescale check failed");

// Check a condition in the cycle after its trigger.
`define RMD_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("rescale check failed");

`endif

### src/rmd_pkg.sv
`default_nettype none
package rmd_pkg;

	// Operand and quotient width inside the datapath.
	localparam int WIDTH  = 64;
	// Width of the payload ports.
	localparam int PORT_W = 64;
	// Split of each operand for the partial products.
	localparam int HALF_W = (WIDTH + 1) / 2;
	localparam int HIGH_W = WIDTH - HALF_W;
	// Double-width numerator, one division cell per numerator bit.
	localparam int NUM_W  = 2 * WIDTH;
	localparam int CELLS  = NUM_W;
	// Cycles from an accepted request to its result when nothing stalls.
	localparam int MUL_STAGES = 4;
	localparam int LATENCY    = MUL_STAGES + CELLS;

	// Data handed from one division cell to the next. The numerator bits
	// shift out at the top of nq while quotient bits shift in at the bottom.
	typedef struct packed {
		logic [WIDTH-1:0] rem;
		logic [NUM_W-1:0] nq;
		logic [WIDTH-1:0] div;
	} rmd_lane_t;

endpackage
`default_nettype wire

### src/rounded_multiply_divide_u64.sv
// Rounded rescale: quotient = (value * multiplier + divisor/2) / divisor.
// Request channel: value, multiplier, divisor with in_valid; the block
// drives in_stall. A request is taken at a clock edge with in_valid high and
// in_stall low. Result channel: quotient, overflow, divide_by_zero with
// out_valid; the receiver drives out_stall.
// Throughput: one request per cycle while out_stall is low. The datapath is
// four multiply and rounding stages, then a row of 2*WIDTH subtract cells,
// one quotient bit per cell.
// overflow flags a quotient of 2^WIDTH or more (low bits still returned).
// A zero divisor returns all ones with divide_by_zero set.
// Reset empties the pipeline; requests in flight are dropped and no result
// is shown until a new request has passed through.
// While out_stall is high the result holds; stages behind it keep filling
// any empty slots and in_stall rises only once the pipeline is full.
// With out_stall low, in_stall is low.
`default_nettype none
`include "rounded_multiply_divide_u64_macros.svh"
module rounded_multiply_divide_u64 (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [rmd_pkg::PORT_W-1:0] value,
	input  wire logic [rmd_pkg::PORT_W-1:0] multiplier,
	input  wire logic [rmd_pkg::PORT_W-1:0] divisor,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [rmd_pkg::PORT_W-1:0]      quotient,
	output logic                           overflow,
	output logic                           divide_by_zero
);

	logic                 mul_ready;
	logic                 chain_valid [0:rmd_pkg::CELLS];
	logic                 chain_ready [0:rmd_pkg::CELLS];
	rmd_pkg::rmd_lane_t   chain_lane  [0:rmd_pkg::CELLS];
	rmd_pkg::rmd_lane_t   last;
	logic                 zero_div;

	// Multiply and round front end.
	rmd_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (mul_ready),
		.a        (value[rmd_pkg::WIDTH-1:0]),
		.b        (multiplier[rmd_pkg::WIDTH-1:0]),
		.c        (divisor[rmd_pkg::WIDTH-1:0]),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_lane  (chain_lane[0])
	);

	// Row of division cells, one quotient bit each.
	for (genvar k = 0; k < rmd_pkg::CELLS; k++) begin : g_cell
		rmd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_lane  (chain_lane[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_lane  (chain_lane[k+1])
		);
	end

	assign in_stall                    = !mul_ready;
	assign chain_ready[rmd_pkg::CELLS] = !out_stall;

	// Decode the result from the last cell.
	assign last      = chain_lane[rmd_pkg::CELLS];
	assign zero_div  = (last.div == '0);
	assign out_valid = chain_valid[rmd_pkg::CELLS];

	always_comb begin
		if (zero_div) begin
			quotient       = rmd_pkg::PORT_W'({rmd_pkg::WIDTH{1'b1}});
			overflow       = 1'b0;
			divide_by_zero = 1'b1;
		end else begin
			quotient       = rmd_pkg::PORT_W'(last.nq[rmd_pkg::WIDTH-1:0]);
			overflow       = |last.nq[rmd_pkg::NUM_W-1:rmd_pkg::WIDTH];
			divide_by_zero = 1'b0;
		end
	end

	`RMD_ASSERT_SAME(a_free_flow, !out_stall, !in_stall)
	`RMD_ASSERT_NEXT(a_cell0_load, chain_valid[0] && chain_ready[0], chain_valid[1])
	`RMD_ASSERT_SAME(a_rem_bound, out_valid && !zero_div, last.rem < last.div)
	`RMD_ASSERT_SAME(a_flags_excl, out_valid, !(overflow && divide_by_zero))

endmodule
`default_nettype wire

### src/rmd_mul.sv
`default_nettype none
module rmd_mul (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     up_valid,
	output logic                          up_ready,
	input  wire logic [rmd_pkg::WIDTH-1:0] a,
	input  wire logic [rmd_pkg::WIDTH-1:0] b,
	input  wire logic [rmd_pkg::WIDTH-1:0] c,
	output logic                          dn_valid,
	input  wire logic                     dn_ready,
	output rmd_pkg::rmd_lane_t            dn_lane
);

	logic                                v_s1, v_s2, v_s3, v_s4;
	logic                                rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic [2*rmd_pkg::HALF_W-1:0]        p00_s1, p00_s2;
	logic [rmd_pkg::WIDTH-1:0]           p01_s1, p10_s1;
	logic [2*rmd_pkg::HIGH_W-1:0]        p11_s1, p11_s2;
	logic [rmd_pkg::WIDTH:0]             cross_s2;
	logic [rmd_pkg::NUM_W-1:0]           prod_s3;
	logic [rmd_pkg::WIDTH-1:0]           c_s1, c_s2, c_s3;
	rmd_pkg::rmd_lane_t                  lane_s4;
	logic [rmd_pkg::HALF_W-1:0]          a_lo, b_lo;
	logic [rmd_pkg::HIGH_W-1:0]          a_hi, b_hi;

	assign a_lo = a[rmd_pkg::HALF_W-1:0];
	assign a_hi = a[rmd_pkg::WIDTH-1:rmd_pkg::HALF_W];
	assign b_lo = b[rmd_pkg::HALF_W-1:0];
	assign b_hi = b[rmd_pkg::WIDTH-1:rmd_pkg::HALF_W];

	// A stage takes new data when empty or when its own data moves on.
	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// Advance valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Form the four partial products.
	always_ff @(posedge clk) begin
		if (up_valid && rdy_s1) begin
			p00_s1 <= a_lo * b_lo;
			p01_s1 <= a_lo * b_hi;
			p10_s1 <= a_hi * b_lo;
			p11_s1 <= a_hi * b_hi;
			c_s1   <= c;
		end
	end

	// Sum the two cross terms.
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			cross_s2 <= (rmd_pkg::WIDTH+1)'(p01_s1) + (rmd_pkg::WIDTH+1)'(p10_s1);
			p00_s2   <= p00_s1;
			p11_s2   <= p11_s1;
			c_s2     <= c_s1;
		end
	end

	// Assemble the full product.
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			prod_s3 <= {p11_s2, p00_s2}
				+ (rmd_pkg::NUM_W'(cross_s2) << rmd_pkg::HALF_W);
			c_s3    <= c_s2;
		end
	end

	// Add half the divisor for round to nearest.
	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			lane_s4.rem <= '0;
			lane_s4.nq  <= prod_s3 + rmd_pkg::NUM_W'(c_s3 >> 1);
			lane_s4.div <= c_s3;
		end
	end

	assign dn_valid = v_s4;
	assign dn_lane  = lane_s4;

endmodule
`default_nettype wire

### src/rmd_div_cell.sv
`default_nettype none
module rmd_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire rmd_pkg::rmd_lane_t up_lane,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output rmd_pkg::rmd_lane_t dn_lane
);

	logic                      valid_q;
	rmd_pkg::rmd_lane_t        lane_q;
	logic [rmd_pkg::WIDTH:0]   trial;
	logic [rmd_pkg::WIDTH:0]   div_x;
	logic [rmd_pkg::WIDTH:0]   diff;
	logic                      qbit;

	// Shift the next numerator bit into the remainder and try one subtract.
	assign trial = {up_lane.rem, up_lane.nq[rmd_pkg::NUM_W-1]};
	assign div_x = {1'b0, up_lane.div};
	assign diff  = trial - div_x;
	assign qbit  = (trial >= div_x);

	assign up_ready = !valid_q || dn_ready;

	// Hold the flag until the next cell takes the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Restore or keep the difference, append the quotient bit.
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			lane_q.rem <= qbit ? diff[rmd_pkg::WIDTH-1:0] : trial[rmd_pkg::WIDTH-1:0];
			lane_q.nq  <= {up_lane.nq[rmd_pkg::NUM_W-2:0], qbit};
			lane_q.div <= up_lane.div;
		end
	end

	assign dn_valid = valid_q;
	assign dn_lane  = lane_q;

endmodule
`default_nettype wire
